FILE: rtl/prs_pkg.sv
`default_nettype none

package prs_pkg;

  // Table geometry.
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned SPAN_W = (AW > IDX_W) ? AW : IDX_W;

  // Number formats.
  localparam int unsigned W_W    = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned SUM_W  = W_W + 1 + AW;

  // One in Q16.16, with a spare carry bit for the saturating add.
  localparam logic [W_W:0] DEP_ONE = (W_W + 1)'(1) << FRAC_W;

  // Operation codes carried in tuser.
  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_DECAY   = 2'd1,
    OP_DEPOSIT = 2'd2
  } op_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MIN_INDEX   = 2'd0,
    REG_MAX_INDEX   = 2'd1,
    REG_DECAY       = 2'd2,
    REG_BASELINE    = 2'd3
  } cfg_reg_e;

  // Controls for the per-entry update unit.
  typedef struct packed {
    op_e                op;
    logic [IDX_W-1:0]   target;
    logic [FRAC_W-1:0]  decay_factor;
  } upd_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/pheromone_roulette_sampler.sv
`default_nettype none

// Pheromone roulette sampler. Holds sixteen Q16.16 weights in a table with
// one read and one write port and a registered read, and works on one
// operation at a time, walking the window min_index..max_index one entry per
// cycle. A decay or deposit beat reads, modifies and writes back each entry of
// the window, streaming through the table ports. A sample takes one pass to
// total the weights, a state to form the threshold with the multiplier, and a
// scan pass that stops at the chosen entry. The table starts cleared after
// reset through per-entry valid bits, so no clearing pass is needed.
// The result beat waits in an output register and does not block the next
// input beat unless a second sample finishes while it is still held.
module pheromone_roulette_sampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input beats.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [3:0] target_index, [19:4] random_fraction
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] op
  // Result beats.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [3:0] chosen_index
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned Depth = prs_pkg::DEPTH;
  localparam int unsigned AW    = prs_pkg::AW;
  localparam int unsigned IdxW  = prs_pkg::IDX_W;
  localparam int unsigned WW    = prs_pkg::W_W;
  localparam int unsigned FW    = prs_pkg::FRAC_W;
  localparam int unsigned SumW  = prs_pkg::SUM_W;
  localparam int unsigned ProdW = SumW + FW;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SUM    = 6'b000010,
    ST_THRESH = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_RESULT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [IdxW-1:0] cfg_min_q, cfg_max_q;
  logic [FW-1:0]   cfg_decay_q;
  logic [WW-1:0]   cfg_base_q;

  // Latched operation.
  prs_pkg::op_e    op_q, op_d;
  logic [IdxW-1:0] target_q, target_d;
  logic [FW-1:0]   frac_q, frac_d;
  logic [AW-1:0]   lo_q, lo_d, hi_q, hi_d;

  // Walk through the table.
  logic [AW-1:0]   ptr_q, ptr_d;
  logic            issue_done_q, issue_done_d;
  logic            rd_pend_q, rd_pend_d;
  logic            rd_last_q, rd_last_d;
  logic [AW-1:0]   rd_addr_q, rd_addr_d;
  logic [WW-1:0]   rdata_q;
  logic [WW-1:0]   mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic            mem_we;

  // Sampling arithmetic.
  logic [SumW-1:0] acc_q, acc_d;
  logic [SumW-1:0] thresh_q, thresh_d;
  logic [IdxW-1:0] chosen_q, chosen_d;
  logic [ProdW-1:0] thr_prod;
  logic [WW-1:0]   w_eff;
  logic [SumW-1:0] run;

  // Output register.
  logic            out_valid_q;
  logic [IdxW-1:0] out_data_q;
  logic            load_out;

  logic            in_accept;
  logic [IdxW-1:0] win_top;
  logic            win_empty;
  logic [WW-1:0]   upd_weight;
  prs_pkg::upd_ctrl_t upd_ctrl;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(8 - IdxW){1'b0}}, out_data_q};

  // Window clipped to the table.
  assign win_top   = (32'(cfg_max_q) > Depth - 1) ? IdxW'(Depth - 1) : cfg_max_q;
  assign win_empty = (cfg_min_q > win_top);

  // Entries never written read as zero.
  assign w_eff    = vld_q[rd_addr_q] ? rdata_q : '0;
  assign run      = acc_q + SumW'(w_eff) + SumW'(cfg_base_q);
  assign thr_prod = ProdW'(acc_q) * ProdW'(frac_q);

  assign upd_ctrl = '{op: op_q, target: target_q, decay_factor: cfg_decay_q};

  prs_update u_update (
    .weight_i (w_eff),
    .addr_i   (rd_addr_q),
    .ctrl_i   (upd_ctrl),
    .weight_o (upd_weight)
  );

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    target_d     = target_q;
    frac_d       = frac_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    ptr_d        = ptr_q;
    issue_done_d = issue_done_q;
    rd_pend_d    = 1'b0;
    rd_last_d    = rd_last_q;
    rd_addr_d    = rd_addr_q;
    acc_d        = acc_q;
    thresh_d     = thresh_q;
    chosen_d     = chosen_q;
    load_out     = 1'b0;
    mem_we       = 1'b0;

    // Read issue, one entry per cycle while a pass runs.
    if ((state_q == ST_SUM || state_q == ST_SCAN || state_q == ST_UPDATE) &&
        !issue_done_q) begin
      rd_pend_d = 1'b1;
      rd_addr_d = ptr_q;
      rd_last_d = (ptr_q == hi_q);
      if (ptr_q == hi_q) begin
        issue_done_d = 1'b1;
      end else begin
        ptr_d = ptr_q + 1'b1;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_d         = prs_pkg::op_e'(s_axis_tuser_i);
          target_d     = s_axis_tdata_i[3:0];
          frac_d       = s_axis_tdata_i[19:4];
          lo_d         = AW'(cfg_min_q);
          hi_d         = AW'(win_top);
          ptr_d        = AW'(cfg_min_q);
          issue_done_d = 1'b0;
          acc_d        = '0;
          case (prs_pkg::op_e'(s_axis_tuser_i)) inside
            prs_pkg::OP_SAMPLE: begin
              if (win_empty) begin
                chosen_d = cfg_max_q;
                state_d  = ST_RESULT;
              end else begin
                state_d  = ST_SUM;
              end
            end
            prs_pkg::OP_DECAY, prs_pkg::OP_DEPOSIT: begin
              if (!win_empty) begin
                state_d = ST_UPDATE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SUM: begin
        if (rd_pend_q) begin
          acc_d = run;
          if (rd_last_q) begin
            state_d = ST_THRESH;
          end
        end
      end
      ST_THRESH: begin
        thresh_d     = thr_prod[ProdW-1:FW];
        acc_d        = '0;
        ptr_d        = lo_q;
        issue_done_d = 1'b0;
        state_d      = ST_SCAN;
      end
      ST_SCAN: begin
        if (rd_pend_q) begin
          acc_d = run;
          if (run > thresh_q) begin
            chosen_d     = IdxW'(rd_addr_q);
            issue_done_d = 1'b1;
            rd_pend_d    = 1'b0;
            state_d      = ST_RESULT;
          end else if (rd_last_q) begin
            chosen_d = cfg_max_q;
            state_d  = ST_RESULT;
          end
        end
      end
      ST_UPDATE: begin
        if (rd_pend_q) begin
          mem_we = 1'b1;
          if (rd_last_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      issue_done_q <= 1'b1;
      rd_pend_q    <= 1'b0;
      vld_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      issue_done_q <= issue_done_d;
      rd_pend_q    <= rd_pend_d;
      if (mem_we) begin
        vld_q[rd_addr_q] <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_min_q   <= IdxW'(0);
      cfg_max_q   <= IdxW'(15);
      cfg_decay_q <= FW'(58982);
      cfg_base_q  <= WW'(65536);
    end else if (cfg_valid_i) begin
      unique case (prs_pkg::cfg_reg_e'(cfg_index_i))
        prs_pkg::REG_MIN_INDEX: cfg_min_q   <= cfg_data_i[IdxW-1:0];
        prs_pkg::REG_MAX_INDEX: cfg_max_q   <= cfg_data_i[IdxW-1:0];
        prs_pkg::REG_DECAY:     cfg_decay_q <= cfg_data_i[FW-1:0];
        prs_pkg::REG_BASELINE:  cfg_base_q  <= cfg_data_i[WW-1:0];
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    target_q  <= target_d;
    frac_q    <= frac_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    ptr_q     <= ptr_d;
    rd_last_q <= rd_last_d;
    rd_addr_q <= rd_addr_d;
    acc_q     <= acc_d;
    thresh_q  <= thresh_d;
    chosen_q  <= chosen_d;
    if (load_out) begin
      out_data_q <= chosen_q;
    end
  end

  // Weight table: registered read, write back of the modified entry.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[rd_addr_q] <= upd_weight;
    end
    rdata_q <= mem_q[ptr_q];
  end

  // Read data only arrives while a pass is running.
  a_pend_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_SUM || state_q == ST_SCAN || state_q == ST_UPDATE))
    else $error("read data pending outside a table pass");

  // Only decay and deposit write the table.
  a_write_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_UPDATE &&
                (op_q == prs_pkg::OP_DECAY || op_q == prs_pkg::OP_DEPOSIT)))
    else $error("table written outside an update pass");

  // Every entry touched lies inside the latched window.
  a_addr_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (rd_addr_q >= lo_q && rd_addr_q <= hi_q))
    else $error("table access outside the window");

  // Once the last read of a pass is pending, issuing has stopped.
  a_last_stops_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_pend_q && rd_last_q) |-> issue_done_q)
    else $error("reads continue past the end of the window");

  // A result beat appears only after a sample has finished.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESULT))
    else $error("result beat raised without a finished sample");

endmodule

`default_nettype wire

FILE: rtl/prs_update.sv
`default_nettype none

module prs_update (
  input  logic [prs_pkg::W_W-1:0] weight_i,
  input  logic [prs_pkg::AW-1:0]  addr_i,
  input  prs_pkg::upd_ctrl_t      ctrl_i,
  output logic [prs_pkg::W_W-1:0] weight_o
);

  localparam int unsigned SpanW = prs_pkg::SPAN_W;
  localparam int unsigned WW    = prs_pkg::W_W;
  localparam int unsigned FW    = prs_pkg::FRAC_W;

  logic [SpanW-1:0]  addr_ext;
  logic [SpanW-1:0]  tgt_ext;
  logic [SpanW-1:0]  gap;
  logic [WW:0]       term;
  logic [WW:0]       dep_sum;
  logic [WW+FW-1:0]  prod;

  // Distance from the deposit centre; the term halves with each step.
  assign addr_ext = SpanW'(addr_i);
  assign tgt_ext  = SpanW'(ctrl_i.target);
  assign gap      = (addr_ext >= tgt_ext) ? (addr_ext - tgt_ext) : (tgt_ext - addr_ext);
  assign term     = prs_pkg::DEP_ONE >> gap;
  assign dep_sum  = {1'b0, weight_i} + term;

  // Decay truncates weight times the Q0.16 factor back to Q16.16.
  assign prod = (WW + FW)'(weight_i) * (WW + FW)'(ctrl_i.decay_factor);

  always_comb begin
    case (ctrl_i.op)
      prs_pkg::OP_DECAY:   weight_o = prod[WW+FW-1:FW];
      prs_pkg::OP_DEPOSIT: weight_o = dep_sum[WW] ? {WW{1'b1}} : dep_sum[WW-1:0];
      default:             weight_o = weight_i;
    endcase
  end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // The fourth op code has no meaning and must be ignored by the block.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Longest operation is a full-window sample; allow margin.
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS = 40;
  localparam int PHASE_BEATS = 128;
  localparam int RANDOM_PHASES = 9;

  typedef struct {
    logic [1:0]  op;
    logic [3:0]  target;
    logic [15:0] frac;
  } trail_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;   // [3:0] target_index, [19:4] random_fraction
  logic [1:0]  s_axis_tuser_i = '0;   // [1:0] op
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;        // [3:0] chosen_index
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  // Mirror of the pheromone table and the window settings.
  logic [prs_pkg::W_W-1:0] weight_tab [prs_pkg::DEPTH];
  logic [3:0]     cfg_min  = 4'd0;
  logic [3:0]     cfg_max  = 4'd15;
  logic [15:0]    cfg_decay = 16'd58982;
  logic [31:0]    cfg_base = 32'd65536;

  trail_beat_t beat_q [$];
  logic [3:0]  pick_q [$];
  trail_beat_t beat_on_bus;
  logic [3:0]  pick_exp;

  int send_idle_pct = 36;
  int recv_idle_pct = 58;
  int beats_queued = 0;
  int beats_taken = 0;
  int picks_checked = 0;
  int cfg_writes = 0;
  int mismatch_cnt = 0;

  pheromone_roulette_sampler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("Timed out with %0d results outstanding.", pick_q.size());
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatch_cnt++;
  endtask

  // Window clipped to the table; returns zero when it is empty.
  function automatic bit window_span(output int lo, output int hi);
    hi = (int'(cfg_max) > prs_pkg::DEPTH - 1) ? prs_pkg::DEPTH - 1 : int'(cfg_max);
    lo = int'(cfg_min);
    return (lo <= hi);
  endfunction

  // Roulette-wheel draw over weight plus baseline across the window.
  function automatic logic [3:0] roulette_pick(input logic [15:0] frac);
    logic [63:0] total;
    logic [63:0] thresh;
    logic [63:0] run;
    int lo;
    int hi;
    if (!window_span(lo, hi)) return cfg_max;
    total = '0;
    for (int i = lo; i <= hi; i++) total += 64'(weight_tab[i]) + 64'(cfg_base);
    thresh = (total * 64'(frac)) >> prs_pkg::FRAC_W;
    run = '0;
    for (int i = lo; i <= hi; i++) begin
      run += 64'(weight_tab[i]) + 64'(cfg_base);
      if (run > thresh) return 4'(i);
    end
    return cfg_max;
  endfunction

  // Evaporation: scale every entry of the window by the Q0.16 factor.
  task automatic evaporate_window();
    int lo;
    int hi;
    if (window_span(lo, hi)) begin
      for (int i = lo; i <= hi; i++) begin
        weight_tab[i] = 32'((64'(weight_tab[i]) * 64'(cfg_decay)) >> prs_pkg::FRAC_W);
      end
    end
  endtask

  // Deposit: add 2^-distance around the centre, saturating at all ones.
  task automatic lay_trail(input logic [3:0] centre);
    int lo;
    int hi;
    int gap;
    logic [63:0] sum;
    if (window_span(lo, hi)) begin
      for (int i = lo; i <= hi; i++) begin
        gap = (i >= int'(centre)) ? i - int'(centre) : int'(centre) - i;
        sum = 64'(weight_tab[i]) + ((gap <= 16) ? (64'(1) << (16 - gap)) : 64'(0));
        weight_tab[i] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      end
    end
  endtask

  // Input driver: predicts each accepted beat, then loads the next one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        beats_taken++;
        case (beat_on_bus.op)
          prs_pkg::OP_SAMPLE:
            pick_q.insert(pick_q.size(), roulette_pick(beat_on_bus.frac));
          prs_pkg::OP_DECAY:   evaporate_window();
          prs_pkg::OP_DEPOSIT: lay_trail(beat_on_bus.target);
          default: ;
        endcase
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || !s_axis_tvalid_i) begin
        if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          beat_on_bus = beat_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {4'b0, beat_on_bus.frac, beat_on_bus.target};
          s_axis_tuser_i  <= beat_on_bus.op;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each result beat with the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pick_q.size() == 0) begin
          report_mismatch($sformatf("index %0d with no sample pending",
                                    m_axis_tdata_o[3:0]));
        end else begin
          pick_exp = pick_q.pop_front();
          picks_checked++;
          if (m_axis_tdata_o[3:0] !== pick_exp) begin
            report_mismatch($sformatf("chosen_index %0d, predicted %0d",
                                      m_axis_tdata_o[3:0], pick_exp));
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_beat(input logic [1:0] op, input logic [3:0] target,
                           input logic [15:0] frac);
    trail_beat_t b;
    b.op = op;
    b.target = target;
    b.frac = frac;
    beat_q.insert(beat_q.size(), b);
    beats_queued++;
  endtask

  // Wait for every beat to be taken and every result to arrive, then let
  // any decay or deposit still in flight finish.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (beats_taken != beats_queued || pick_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write; unused upper data bits carry noise.
  task automatic write_reg(input prs_pkg::cfg_reg_e idx, input logic [31:0] val);
    logic [31:0] noise;
    noise = $urandom();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    case (idx) inside
      prs_pkg::REG_MIN_INDEX, prs_pkg::REG_MAX_INDEX:
        cfg_data_i <= {noise[31:4], val[3:0]};
      prs_pkg::REG_DECAY: cfg_data_i <= {noise[31:16], val[15:0]};
      default:            cfg_data_i <= val;
    endcase
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    case (idx)
      prs_pkg::REG_MIN_INDEX: cfg_min = val[3:0];
      prs_pkg::REG_MAX_INDEX: cfg_max = val[3:0];
      prs_pkg::REG_DECAY:     cfg_decay = val[15:0];
      default:                cfg_base = val;
    endcase
  endtask

  task automatic apply_setting(input logic [3:0] lo, input logic [3:0] hi,
                               input logic [15:0] decay, input logic [31:0] base);
    write_reg(prs_pkg::REG_MIN_INDEX, 32'(lo));
    write_reg(prs_pkg::REG_MAX_INDEX, 32'(hi));
    write_reg(prs_pkg::REG_DECAY, 32'(decay));
    write_reg(prs_pkg::REG_BASELINE, base);
  endtask

  // Mostly samples and deposits, some decays, a few ignored beats.
  task automatic push_random_beat();
    int pick;
    logic [15:0] frac;
    pick = $urandom_range(99);
    frac = 16'($urandom());
    if ($urandom_range(15) == 0) frac = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    if (pick < 40)      push_beat(prs_pkg::OP_DEPOSIT, 4'($urandom()), frac);
    else if (pick < 80) push_beat(prs_pkg::OP_SAMPLE, 4'($urandom()), frac);
    else if (pick < 95) push_beat(prs_pkg::OP_DECAY, 4'($urandom()), frac);
    else                push_beat(OP_UNUSED, 4'($urandom()), frac);
  endtask

  // Window and number settings for each random phase, extremes first.
  task automatic random_setting(input int k);
    logic [3:0]  lo;
    logic [3:0]  hi;
    logic [15:0] decay;
    logic [31:0] base;
    lo = 4'($urandom_range(7));
    hi = 4'($urandom_range(15, 8));
    decay = 16'($urandom_range(65535, 40000));
    base = $urandom_range(32'h0002_0000);
    case (k)
      0: begin lo = 4'd0; hi = 4'd15; end
      1: begin lo = 4'd0; hi = 4'd15; decay = 16'h0000; base = 32'h0; end
      2: begin lo = 4'd15; hi = 4'd15; decay = 16'hFFFF; base = 32'hFFFF_FFFF; end
      4: begin lo = 4'($urandom_range(15, 9)); hi = 4'($urandom_range(8)); end
      5: base = $urandom();
      default: ;
    endcase
    apply_setting(lo, hi, decay, base);
  endtask

  initial begin
    for (int i = 0; i < prs_pkg::DEPTH; i++) weight_tab[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: flat table at reset settings, op extremes and the ignored op.
    push_beat(prs_pkg::OP_SAMPLE, 4'h0, 16'h0000);
    push_beat(prs_pkg::OP_SAMPLE, 4'hF, 16'hFFFF);
    push_beat(prs_pkg::OP_SAMPLE, 4'h0, 16'h8000);
    push_beat(OP_UNUSED, 4'hF, 16'hFFFF);
    push_beat(prs_pkg::OP_DEPOSIT, 4'h0, 16'hFFFF);
    push_beat(prs_pkg::OP_DEPOSIT, 4'hF, 16'h0000);
    push_beat(prs_pkg::OP_DEPOSIT, 4'h7, 16'h5A5A);
    push_beat(prs_pkg::OP_SAMPLE, 4'h0, 16'h0000);
    push_beat(prs_pkg::OP_SAMPLE, 4'h0, 16'hFFFF);
    push_beat(prs_pkg::OP_SAMPLE, 4'h0, 16'h2000);
    push_beat(prs_pkg::OP_DECAY, 4'h0, 16'h0000);
    push_beat(prs_pkg::OP_SAMPLE, 4'hA, 16'hA5A5);
    push_beat(prs_pkg::OP_DEPOSIT, 4'h8, 16'h0000);
    push_beat(prs_pkg::OP_SAMPLE, 4'h0, 16'hC000);
    wait_drained();

    // Zero total: decay to nothing and no baseline.
    apply_setting(4'd0, 4'd15, 16'h0000, 32'h0);
    push_beat(prs_pkg::OP_DECAY, 4'h3, 16'h0000);
    push_beat(prs_pkg::OP_SAMPLE, 4'h0, 16'hFFFF);
    push_beat(prs_pkg::OP_SAMPLE, 4'h0, 16'h0000);
    wait_drained();

    // Empty window: min above max.
    apply_setting(4'd9, 4'd3, 16'd58982, 32'd65536);
    push_beat(prs_pkg::OP_DEPOSIT, 4'h5, 16'h1111);
    push_beat(prs_pkg::OP_DECAY, 4'h0, 16'h0000);
    push_beat(prs_pkg::OP_SAMPLE, 4'h0, 16'h8000);
    wait_drained();

    // Single-entry window and widest numbers.
    apply_setting(4'd15, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
    push_beat(prs_pkg::OP_DEPOSIT, 4'hF, 16'h0000);
    push_beat(prs_pkg::OP_DECAY, 4'h0, 16'h0000);
    push_beat(prs_pkg::OP_SAMPLE, 4'h0, 16'hFFFF);
    push_beat(prs_pkg::OP_SAMPLE, 4'h0, 16'h0000);
    wait_drained();
    apply_setting(4'd0, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
    push_beat(prs_pkg::OP_SAMPLE, 4'h0, 16'hFFFF);
    wait_drained();

    // Random phases; idling swaps sides after three and stops after six.
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      if (k == 3) begin
        send_idle_pct = 58;
        recv_idle_pct = 36;
      end else if (k == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_setting(k);
      for (int n = 0; n < PHASE_BEATS; n++) push_random_beat();
      wait_drained();
    end

    if (pick_q.size() != 0) report_mismatch("samples left without a result");
    $display("Covered %0d input beats over %0d register writes, %0d draws checked.",
             beats_taken, cfg_writes, picks_checked);
    $display("Settings spanned empty, single-entry and full windows; %0d mismatches.",
             mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
